// ===== rtl/cantp_pkg.sv =====
package cantp_pkg;

  // Default receive buffer size in bytes.
  localparam int BUFFER_BYTES_DEF = 2048;

  // A data frame carries seven bytes; eight buffer banks take them all in the same cycle.
  localparam int NUM_BANKS = 8;
  localparam int BANK_W    = 3;
  localparam int DT_BYTES  = 7;

  // Field widths fixed by the frame and result formats.
  localparam int MSG_LEN_W = 11;
  localparam int IDX_W     = 11;
  localparam int CFG_W     = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_ADDR = 2'd0;
  localparam logic [1:0] REG_SRC_FILT  = 2'd1;
  localparam logic [1:0] REG_SRC_MASK  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // Input beat kinds.
  localparam logic [1:0] KIND_CM   = 2'd0;
  localparam logic [1:0] KIND_DT   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  // Session modes as reported on receive_mode.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_RTS     = 3'd1;
  localparam logic [2:0] MODE_BAM     = 3'd2;
  localparam logic [2:0] MODE_NEW     = 3'd3;
  localparam logic [2:0] MODE_TIMEOUT = 3'd4;
  localparam logic [2:0] MODE_ABORT   = 3'd5;

  // Connection management control bytes.
  localparam logic [7:0] CTL_RTS   = 8'd16;
  localparam logic [7:0] CTL_BAM   = 8'd32;
  localparam logic [7:0] CTL_ABORT = 8'hFF;

  // Reply codes.
  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_CTS   = 2'd1;
  localparam logic [1:0] REPLY_ACK   = 2'd2;
  localparam logic [1:0] REPLY_ABORT = 2'd3;

  // Abort reasons.
  localparam logic [7:0] ABORT_BUSY      = 8'd1;
  localparam logic [7:0] ABORT_RESOURCES = 8'd2;

  // PDU2 format threshold: the PS byte is part of the PGN from here on.
  localparam logic [7:0] PF_PDU2 = 8'd240;
  localparam logic [7:0] BYTE_FILL = 8'hFF;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       frame_source;
    logic [7:0]       frame_dest;
    logic [63:0]      payload;
    logic [IDX_W-1:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]           reply_code;
    logic [7:0]           reply_dest;
    logic [7:0]           reply_byte1;
    logic [7:0]           reply_byte2;
    logic [7:0]           reply_byte3;
    logic [15:0]          reply_pgn;
    logic [2:0]           receive_mode;
    logic [MSG_LEN_W-1:0] message_length;
    logic [15:0]          message_pgn;
    logic [7:0]           message_source;
    logic [7:0]           read_data;
  } out_beat_t;

endpackage

// ===== rtl/cantp_ram.sv =====
module cantp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cantp_bank.sv =====
module cantp_bank
  import cantp_pkg::*;
#(
  parameter int BANK     = 0,
  parameter int POS_W    = 11,
  parameter int BANK_DEP = 256
) (
  input  logic                        clk,
  input  logic                        wr_req,
  input  logic [POS_W-1:0]            base,
  input  logic [POS_W-1:0]            length,
  input  logic [63:0]                 payload,
  input  logic                        rd_en,
  input  logic [$clog2(BANK_DEP)-1:0] rd_addr,
  output logic [7:0]                  rd_data
);

  localparam int AW = $clog2(BANK_DEP);

  logic [BANK_W-1:0] lane;
  logic [BANK_W-1:0] byte_sel;
  logic [POS_W-1:0]  pos;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;

  // The frame byte that lands in this bank is the one whose buffer position
  // has the bank number in its low bits; lane seven means no byte this frame.
  assign lane     = BANK_W'(BANK) - base[BANK_W-1:0];
  assign byte_sel = lane + BANK_W'(1);
  assign pos      = base + POS_W'(lane);
  assign wr_en    = wr_req && (lane != BANK_W'(DT_BYTES)) && (pos < length);
  assign wr_addr  = pos[AW+BANK_W-1:BANK_W];
  assign wr_data  = payload[8*byte_sel +: 8];

  cantp_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEP)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/can_transport_reassembly_receiver.sv =====
// Receive side of the multi-packet transport protocol. Management frames
// (RTS, BAM, abort), data frames, timer ticks and buffer reads enter as one
// beat each; every beat yields exactly one result beat carrying any reply
// frame (CTS, end-of-message ACK or abort) and the session status. The block
// takes one beat per clock while in_stall is low; each result is registered in
// the middle stage and then the output register. The reassembly buffer is split
// into eight byte-wide banks by the low three bits of the byte address, so all
// seven bytes of a data frame are stored in the cycle that accepts it. A buffer
// read returns the byte in its result beat; reading a byte never written since
// reset returns an undefined value. The buffer needs no clearing after reset.
module can_transport_reassembly_receiver
  import cantp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  localparam int LEN_W    = $clog2(BUFFER_BYTES);
  localparam int POS_W    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam int BANK_DEP = (BUFFER_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int AW       = $clog2(BANK_DEP);
  localparam logic [16:0] BUF_LIM = 17'(BUFFER_BYTES);

  // Configuration registers.
  logic [7:0]  node_addr_r;
  logic [7:0]  src_filt_r;
  logic [7:0]  src_mask_r;
  logic [15:0] timeout_r;

  // Session state.
  logic [2:0]       mode_r, mode_nxt;
  logic [15:0]      ticks_r, ticks_nxt;
  logic             locked_r, locked_nxt;
  logic [7:0]       sess_src_r, sess_src_nxt;
  logic [LEN_W-1:0] sess_len_r, sess_len_nxt;
  logic [15:0]      sess_pgn_r, sess_pgn_nxt;

  // Pipeline registers.
  logic              s1_valid_r;
  out_beat_t         s1_data_r;
  logic              s1_rd_hit_r;
  logic [BANK_W-1:0] s1_rd_bank_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic      accept;
  logic      out_free;
  logic      s1_move;
  out_beat_t res;
  out_beat_t s1_out;

  logic             frame_ok;
  logic             receiving;
  logic [7:0]       ctl;
  logic [15:0]      size;
  logic [7:0]       pf;
  logic [15:0]      new_pgn;
  logic [7:0]       packet;
  logic [7:0]       pkt_m1;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] len_ext;
  logic             dt_done;
  logic             dt_wr;
  logic [15:0]      len16;

  logic [POS_W-1:0]  ridx_ext;
  logic              rd_hit;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        bank_q [NUM_BANKS];
  logic [7:0]        rd_byte;

  // Two-stage flow control: a held result stalls input only once both
  // stages are occupied.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Frame filter: own destination, then the session lock or the source pattern.
  assign receiving = (mode_r == MODE_RTS) || (mode_r == MODE_BAM);
  assign frame_ok  = (in_data.frame_dest == node_addr_r) &&
                     (locked_r ? (in_data.frame_source == sess_src_r)
                               : (((in_data.frame_source ^ src_filt_r) & src_mask_r) == 8'd0));

  // Management frame fields.
  assign ctl     = in_data.payload[7:0];
  assign size    = in_data.payload[23:8];
  assign pf      = in_data.payload[55:48];
  assign new_pgn = {pf, (pf >= PF_PDU2) ? in_data.payload[47:40] : 8'd0};

  // Data frame placement: base position is seven bytes per packet.
  assign packet  = in_data.payload[7:0];
  assign pkt_m1  = packet - 8'd1;
  assign base    = (POS_W'(pkt_m1) << 3) - POS_W'(pkt_m1);
  assign len_ext = POS_W'(sess_len_r);
  assign dt_done = ({1'b0, base} + (POS_W+1)'(DT_BYTES)) >= {1'b0, len_ext};
  assign dt_wr   = accept && (in_data.kind == KIND_DT) && frame_ok && receiving &&
                   (packet != 8'd0);
  assign len16   = 16'(sess_len_r);

  // Buffer read address split into bank and row.
  assign ridx_ext = POS_W'(in_data.read_index);
  assign rd_hit   = {6'd0, in_data.read_index} < BUF_LIM;
  assign rd_en    = accept && (in_data.kind == KIND_READ);
  assign rd_addr  = ridx_ext[AW+BANK_W-1:BANK_W];

  // Session control and reply formation.
  always_comb begin
    mode_nxt     = mode_r;
    ticks_nxt    = ticks_r;
    locked_nxt   = locked_r;
    sess_src_nxt = sess_src_r;
    sess_len_nxt = sess_len_r;
    sess_pgn_nxt = sess_pgn_r;
    res          = '0;
    if (accept) begin
      unique case (in_data.kind)
        KIND_CM: begin
          if (frame_ok) begin
            ticks_nxt = 16'd0;
            if ((ctl == CTL_RTS) || (ctl == CTL_BAM)) begin
              if (!receiving && ({1'b0, size} < BUF_LIM)) begin
                sess_len_nxt = LEN_W'(size);
                sess_pgn_nxt = new_pgn;
                sess_src_nxt = in_data.frame_source;
                locked_nxt   = 1'b1;
                if (ctl == CTL_RTS) begin
                  mode_nxt        = MODE_RTS;
                  res.reply_code  = REPLY_CTS;
                  res.reply_dest  = in_data.frame_source;
                  res.reply_byte1 = in_data.payload[31:24];
                  res.reply_byte2 = 8'd1;
                  res.reply_byte3 = BYTE_FILL;
                  res.reply_pgn   = new_pgn;
                end else begin
                  mode_nxt = MODE_BAM;
                end
              end else if (ctl == CTL_RTS) begin
                res.reply_code  = REPLY_ABORT;
                res.reply_dest  = in_data.frame_source;
                res.reply_byte1 = (mode_r != MODE_IDLE) ? ABORT_BUSY : ABORT_RESOURCES;
                res.reply_byte2 = BYTE_FILL;
                res.reply_byte3 = BYTE_FILL;
                res.reply_pgn   = sess_pgn_r;
              end
            end else if (ctl == CTL_ABORT) begin
              mode_nxt = MODE_ABORT;
            end
          end
        end
        KIND_DT: begin
          if (frame_ok) begin
            ticks_nxt = 16'd0;
            if (receiving && (packet != 8'd0) && dt_done) begin
              if (mode_r == MODE_RTS) begin
                res.reply_code  = REPLY_ACK;
                res.reply_dest  = sess_src_r;
                res.reply_byte1 = len16[7:0];
                res.reply_byte2 = len16[15:8];
                res.reply_byte3 = packet;
                res.reply_pgn   = sess_pgn_r;
              end
              mode_nxt = MODE_NEW;
            end
          end
        end
        KIND_TICK: begin
          if (receiving) begin
            if (ticks_r < timeout_r) begin
              ticks_nxt = ticks_r + 16'd1;
            end else begin
              locked_nxt = 1'b0;
              mode_nxt   = MODE_TIMEOUT;
            end
          end
        end
        KIND_READ: begin
          // The byte itself comes from the registered bank outputs in the middle stage.
        end
        default: begin
        end
      endcase
    end
    res.receive_mode   = mode_nxt;
    res.message_length = MSG_LEN_W'(sess_len_nxt);
    res.message_pgn    = sess_pgn_nxt;
    res.message_source = sess_src_nxt;
  end

  // Configuration and session registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'd0;
      src_filt_r  <= 8'd0;
      src_mask_r  <= 8'd0;
      timeout_r   <= TIMEOUT_RESET;
      mode_r      <= MODE_IDLE;
      ticks_r     <= 16'd0;
      locked_r    <= 1'b0;
      sess_src_r  <= 8'd0;
      sess_len_r  <= '0;
      sess_pgn_r  <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NODE_ADDR: node_addr_r <= cfg_wdata[7:0];
          REG_SRC_FILT:  src_filt_r  <= cfg_wdata[7:0];
          REG_SRC_MASK:  src_mask_r  <= cfg_wdata[7:0];
          REG_TIMEOUT:   timeout_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      mode_r     <= mode_nxt;
      ticks_r    <= ticks_nxt;
      locked_r   <= locked_nxt;
      sess_src_r <= sess_src_nxt;
      sess_len_r <= sess_len_nxt;
      sess_pgn_r <= sess_pgn_nxt;
    end
  end

  // Buffer banks: each bank stores the data byte, if any, that maps to it.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    cantp_bank #(
      .BANK     (b),
      .POS_W    (POS_W),
      .BANK_DEP (BANK_DEP)
    ) u_bank (
      .clk     (clk),
      .wr_req  (dt_wr),
      .base    (base),
      .length  (len_ext),
      .payload (in_data.payload),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (bank_q[b])
    );
  end

  // Merge: pick the addressed bank for a read result.
  assign rd_byte = s1_rd_hit_r ? bank_q[s1_rd_bank_r] : 8'd0;

  // Middle-stage beat with the read byte filled in.
  always_comb begin
    s1_out           = s1_data_r;
    s1_out.read_data = rd_byte;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !s1_move);
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r    <= res;
      s1_rd_hit_r  <= rd_en && rd_hit;
      s1_rd_bank_r <= in_data.read_index[BANK_W-1:0];
    end
    if (s1_move) begin
      out_data_r <= s1_out;
    end
  end

  // A receiving session always holds the source lock.
  a_lock_while_rx: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_RTS) || (mode_r == MODE_BAM)) |-> locked_r)
    else $error("receiving session without source lock");

  // A timed-out session has released its lock.
  a_timeout_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_TIMEOUT) |-> !locked_r)
    else $error("lock held after timeout");

  // The stored length always fits the buffer.
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, 16'(sess_len_r)} < BUF_LIM)
    else $error("session length beyond buffer");

  // A blocked middle stage keeps its beat.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("middle stage lost a beat");

endmodule

// ===== test/tb_can_transport_reassembly_receiver.sv =====
`timescale 1ns / 100ps

module tb_can_transport_reassembly_receiver
  import cantp_pkg::*;
();

  localparam int BUF_BYTES = BUFFER_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 210;
  localparam int NUM_PHASES = 8;
  localparam int TICKOUT_MAX = 16;

  // Control byte of a clear-to-send frame; the block takes it as an unknown command.
  localparam logic [7:0] CTL_CTS = 8'd17;
  localparam logic [7:0] PEER = 8'h12;
  localparam logic [7:0] OTHER_PEER = 8'h34;
  localparam logic [7:0] FOREIGN_DEST = 8'h05;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;

  always #2 clk = ~clk;

  can_transport_reassembly_receiver u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Register copies kept in step with the configuration port.
  logic [7:0] node_addr = 8'h00;
  logic [7:0] src_filter = 8'h00;
  logic [7:0] src_mask = 8'h00;
  logic [15:0] tmo_limit = TIMEOUT_RESET;

  // Session state of the receiver as this bench expects it.
  logic [2:0] sess_mode = MODE_IDLE;
  logic [15:0] tick_count = '0;
  bit locked = 1'b0;
  logic [7:0] sess_src = '0;
  logic [10:0] sess_len = '0;
  logic [15:0] sess_pgn = '0;
  logic [7:0] msg_bytes [BUF_BYTES];
  bit byte_written [BUF_BYTES];
  int unsigned written_addrs [$];

  out_beat_t due_status [$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic calm_window;

  typedef struct {
    in_beat_t beat;
    bit typed;
    out_beat_t want;
  } probe_row_t;

  probe_row_t probe_rows [$];

  // A stretch in the middle of the run where neither side holds back.
  assign calm_window = (items_sent >= 700) && (items_sent < 950);

  function automatic bit receiving();
    return sess_mode == MODE_RTS || sess_mode == MODE_BAM;
  endfunction

  function automatic bit frame_passes(logic [7:0] src, logic [7:0] dst);
    if (dst != node_addr) return 1'b0;
    if (locked) return src == sess_src;
    return ((src ^ src_filter) & src_mask) == 8'h00;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] cm_payload(logic [7:0] ctl, logic [15:0] size,
                                             logic [7:0] pkts, logic [7:0] ps,
                                             logic [7:0] pf);
    return {8'($urandom), pf, ps, BYTE_FILL, pkts, size[15:8], size[7:0], ctl};
  endfunction

  function automatic in_beat_t make_beat(logic [1:0] kind, logic [7:0] src, logic [7:0] dst,
                                         logic [63:0] pl, logic [10:0] idx);
    in_beat_t b;
    b.kind = kind;
    b.frame_source = src;
    b.frame_dest = dst;
    b.payload = pl;
    b.read_index = idx;
    return b;
  endfunction

  // A sender that gets past the filter, or the locked sender.
  function automatic logic [7:0] session_sender();
    if (locked) return sess_src;
    return (8'($urandom) & ~src_mask) | (src_filter & src_mask);
  endfunction

  // Advance the expected receiver state by one beat and return its status beat.
  function automatic out_beat_t receive_frame(in_beat_t b);
    out_beat_t r;
    logic [7:0] lead;
    logic [7:0] pf;
    logic [15:0] size;
    int unsigned pos;
    r = '0;
    lead = b.payload[7:0];
    if (b.kind == KIND_CM && frame_passes(b.frame_source, b.frame_dest)) begin
      tick_count = '0;
      if (lead == CTL_RTS || lead == CTL_BAM) begin
        size = b.payload[23:8];
        if (!receiving() && size < BUF_BYTES) begin
          pf = b.payload[55:48];
          sess_len = size[10:0];
          sess_pgn = {pf, (pf >= PF_PDU2) ? b.payload[47:40] : 8'h00};
          sess_src = b.frame_source;
          locked = 1'b1;
          if (lead == CTL_RTS) begin
            sess_mode = MODE_RTS;
            r.reply_code = REPLY_CTS;
            r.reply_dest = b.frame_source;
            r.reply_byte1 = b.payload[31:24];
            r.reply_byte2 = 8'd1;
            r.reply_byte3 = BYTE_FILL;
            r.reply_pgn = sess_pgn;
          end else begin
            sess_mode = MODE_BAM;
          end
        end else if (lead == CTL_RTS) begin
          r.reply_code = REPLY_ABORT;
          r.reply_dest = b.frame_source;
          r.reply_byte1 = (sess_mode != MODE_IDLE) ? ABORT_BUSY : ABORT_RESOURCES;
          r.reply_byte2 = BYTE_FILL;
          r.reply_byte3 = BYTE_FILL;
          r.reply_pgn = sess_pgn;
        end
      end else if (lead == CTL_ABORT) begin
        sess_mode = MODE_ABORT;
      end
    end else if (b.kind == KIND_DT && frame_passes(b.frame_source, b.frame_dest)) begin
      tick_count = '0;
      if (receiving() && lead != 8'h00) begin
        pos = DT_BYTES * (int'(lead) - 1);
        for (int k = 1; k <= DT_BYTES; k++) begin
          if (pos < sess_len) begin
            msg_bytes[pos] = b.payload[8*k +: 8];
            if (!byte_written[pos]) written_addrs.push_back(pos);
            byte_written[pos] = 1'b1;
            pos++;
          end
        end
        if (pos >= sess_len) begin
          if (sess_mode == MODE_RTS) begin
            r.reply_code = REPLY_ACK;
            r.reply_dest = sess_src;
            r.reply_byte1 = sess_len[7:0];
            r.reply_byte2 = {5'b0, sess_len[10:8]};
            r.reply_byte3 = lead;
            r.reply_pgn = sess_pgn;
          end
          sess_mode = MODE_NEW;
        end
      end
    end else if (b.kind == KIND_TICK) begin
      if (receiving()) begin
        if (tick_count < tmo_limit) begin
          tick_count = tick_count + 16'd1;
        end else begin
          locked = 1'b0;
          sess_mode = MODE_TIMEOUT;
        end
      end
    end else if (b.kind == KIND_READ) begin
      r.read_data = msg_bytes[b.read_index];
    end
    r.receive_mode = sess_mode;
    r.message_length = sess_len;
    r.message_pgn = sess_pgn;
    r.message_source = sess_src;
    return r;
  endfunction

  // Present one beat, wait for it to be taken, and queue its expected status.
  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    out_beat_t predicted;
    @(negedge clk);
    while (!calm_window && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = receive_frame(b);
    due_status.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic add_probe(logic [1:0] kind, logic [7:0] src, logic [7:0] dst,
                           logic [63:0] pl, logic [10:0] idx,
                           bit typed = 1'b0, out_beat_t want = '0);
    probe_row_t row;
    row.beat = make_beat(kind, src, dst, pl, idx);
    row.typed = typed;
    row.want = want;
    probe_rows.push_back(row);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The 8-bit registers get junk in their upper byte, which must be dropped.
  task automatic configure(logic [7:0] node, logic [7:0] filt, logic [7:0] mask,
                           logic [15:0] limit);
    write_reg(REG_NODE_ADDR, {8'($urandom), node});
    write_reg(REG_SRC_FILT, {8'($urandom), filt});
    write_reg(REG_SRC_MASK, {8'($urandom), mask});
    write_reg(REG_TIMEOUT, limit);
    node_addr = node;
    src_filter = filt;
    src_mask = mask;
    tmo_limit = limit;
  endtask

  // Drop valid and wait until every status beat is back and the pipeline is empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick();
    send_beat(make_beat(KIND_TICK, 8'($urandom), 8'($urandom), rand64(), 11'($urandom)));
  endtask

  // Reads only touch bytes that a data frame has already stored.
  task automatic send_read();
    logic [10:0] idx;
    if (written_addrs.size() == 0) begin
      send_tick();
    end else begin
      idx = 11'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      send_beat(make_beat(KIND_READ, 8'($urandom), 8'($urandom), rand64(), idx));
    end
  endtask

  task automatic send_data(logic [7:0] pkt);
    logic [63:0] pl;
    pl = rand64();
    pl[7:0] = pkt;
    send_beat(make_beat(KIND_DT, sess_src, node_addr, pl, 11'($urandom)));
  endtask

  task automatic send_abort_frame();
    send_beat(make_beat(KIND_CM, sess_src, node_addr, cm_payload(CTL_ABORT, 16'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom)), 11'($urandom)));
  endtask

  // Enough ticks to run the idle counter past the limit.
  task automatic tick_out();
    repeat (int'(tmo_limit) + 1 + $urandom_range(0, 1)) send_tick();
  endtask

  // Announcement, data frames mostly in order, a few reads, then some way to end.
  task automatic run_session();
    logic [7:0] ctl;
    logic [7:0] pf;
    logic [15:0] size;
    int unsigned n;
    int unsigned r;
    if (receiving() && $urandom_range(0, 1)) send_abort_frame();
    ctl = $urandom_range(0, 1) ? CTL_RTS : CTL_BAM;
    r = $urandom_range(0, 99);
    if (r < 80) size = 16'($urandom_range(0, 48));
    else if (r < 90) size = 16'($urandom_range(49, BUF_BYTES - 1));
    else size = 16'($urandom_range(BUF_BYTES, 16'hFFFF));
    pf = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(240, 255)) : 8'($urandom);
    send_beat(make_beat(KIND_CM, session_sender(), node_addr,
                        cm_payload(ctl, size, 8'($urandom), 8'($urandom), pf),
                        11'($urandom)));
    if (!receiving()) return;
    n = (sess_len == 0) ? 1 : (int'(sess_len) + DT_BYTES - 1) / DT_BYTES;
    if (n > 12) begin
      // Long messages get a few scattered packets only.
      repeat (4) send_data(8'($urandom_range(1, 255)));
    end else begin
      for (int unsigned p = 1; p <= n; p++) begin
        r = $urandom_range(0, 99);
        if (r < 6) continue;
        if (r < 11) send_tick();
        else if (r < 15) send_data(8'h00);
        send_data(8'(p));
        if (r >= 95) send_data(8'(p));
      end
    end
    repeat ($urandom_range(0, 3)) send_read();
    if (receiving()) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_abort_frame();
      else if (r < 70 && tmo_limit <= TICKOUT_MAX) tick_out();
    end
  endtask

  task automatic send_noise();
    logic [1:0] kind;
    logic [7:0] src;
    logic [7:0] dst;
    logic [63:0] pl;
    kind = 2'($urandom_range(0, 3));
    if (kind == KIND_READ) begin
      send_read();
      return;
    end
    src = $urandom_range(0, 1) ? session_sender() : 8'($urandom);
    dst = $urandom_range(0, 1) ? node_addr : 8'($urandom);
    pl = rand64();
    if (kind == KIND_CM) begin
      case ($urandom_range(0, 3))
        0: pl[7:0] = CTL_RTS;
        1: pl[7:0] = CTL_BAM;
        2: pl[7:0] = CTL_ABORT;
        default: ;
      endcase
      if ($urandom_range(0, 1)) pl[23:16] = 8'($urandom_range(0, 7));
    end
    send_beat(make_beat(kind, src, dst, pl, 11'($urandom)));
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned stop;
    int unsigned r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        run_session();
      end else if (r < 65) begin
        if (receiving() && tmo_limit <= TICKOUT_MAX) tick_out();
        else send_tick();
      end else if (r < 78) begin
        send_read();
      end else begin
        send_noise();
      end
    end
  endtask

  // Output side holds back at random, except in the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm_window && ($urandom_range(0, 99) < 18);
  end

  // Compare each status beat with the oldest expectation.
  out_beat_t want_beat;
  bit bad_beat;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("status beat with nothing expected: %h", out_data);
      end else begin
        want_beat = due_status.pop_front();
        bad_beat = (out_data.reply_code !== want_beat.reply_code)
                || (out_data.reply_dest !== want_beat.reply_dest)
                || (out_data.reply_byte1 !== want_beat.reply_byte1)
                || (out_data.reply_byte2 !== want_beat.reply_byte2)
                || (out_data.reply_byte3 !== want_beat.reply_byte3)
                || (out_data.reply_pgn !== want_beat.reply_pgn)
                || (out_data.receive_mode !== want_beat.receive_mode)
                || (out_data.message_length !== want_beat.message_length)
                || (out_data.message_pgn !== want_beat.message_pgn)
                || (out_data.message_source !== want_beat.message_source)
                || (out_data.read_data !== want_beat.read_data);
        if (bad_beat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: got reply %0d/%h/%h/%h/%h/%h mode %0d len %0d",
                     $realtime, out_data.reply_code, out_data.reply_dest,
                     out_data.reply_byte1, out_data.reply_byte2, out_data.reply_byte3,
                     out_data.reply_pgn, out_data.receive_mode, out_data.message_length);
            $display("  got pgn %h src %h data %h", out_data.message_pgn,
                     out_data.message_source, out_data.read_data);
            $display("  expected reply %0d/%h/%h/%h/%h/%h mode %0d len %0d",
                     want_beat.reply_code, want_beat.reply_dest, want_beat.reply_byte1,
                     want_beat.reply_byte2, want_beat.reply_byte3, want_beat.reply_pgn,
                     want_beat.receive_mode, want_beat.message_length);
            $display("  expected pgn %h src %h data %h", want_beat.message_pgn,
                     want_beat.message_source, want_beat.read_data);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_beat_t no_status;
    out_beat_t refusal;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NODE_ADDR;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;

    no_status = '0;
    refusal = '0;
    refusal.reply_code = REPLY_ABORT;
    refusal.reply_dest = PEER;
    refusal.reply_byte1 = ABORT_RESOURCES;
    refusal.reply_byte2 = BYTE_FILL;
    refusal.reply_byte3 = BYTE_FILL;

    // Directed table under reset configuration: node 0, every source accepted.
    add_probe(KIND_TICK, 8'h00, 8'h00, 64'h0, 11'h000, 1'b1, no_status);
    // Oversized RTS while idle is refused for lack of resources.
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_RTS, 16'd2048, 8'h12, 8'h00, 8'hEF),
              11'h000, 1'b1, refusal);
    add_probe(KIND_DT, PEER, 8'h00, 64'hB7B6B5B4B3B2B101, 11'h000, 1'b1, no_status);
    add_probe(KIND_CM, PEER, FOREIGN_DEST, cm_payload(CTL_RTS, 16'd20, 8'd3, 8'hCA, 8'hFE),
              11'h000, 1'b1, no_status);
    // PDU2 session of three packets, then a busy refusal and a filtered sender.
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_RTS, 16'd20, 8'd3, 8'hCA, 8'hFE), 11'h000);
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_RTS, 16'd10, 8'd2, 8'h00, 8'h20), 11'h000);
    add_probe(KIND_CM, OTHER_PEER, 8'h00, cm_payload(CTL_RTS, 16'd10, 8'd2, 8'h00, 8'h20),
              11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'h1122334455667700, 11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'hA7A6A5A4A3A2A101, 11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'hC7C6C5C4C3C2C103, 11'h000);
    add_probe(KIND_READ, 8'h00, 8'h00, 64'h0, 11'd0);
    add_probe(KIND_READ, 8'h00, 8'h00, 64'h0, 11'd19);
    // Broadcast of zero length completes on its first data frame without a reply.
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_BAM, 16'd0, 8'd0, 8'h77, 8'h10), 11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'h0102030405060705, 11'h000);
    // Largest accepted length, and the highest packet number.
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_RTS, 16'd2047, 8'hFF, 8'h55, 8'hEF),
              11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'hFFFFFFFFFFFFFFFF, 11'h7FF);
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_ABORT, 16'd0, 8'd0, 8'h00, 8'h00),
              11'h000);
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_CTS, 16'd0, 8'd0, 8'h00, 8'h00), 11'h000);
    add_probe(KIND_TICK, PEER, 8'h00, 64'h0, 11'h000);
    add_probe(KIND_READ, 8'hFF, 8'hFF, 64'h0, 11'd1784);
    // A packet number past the end stores nothing and still completes the message.
    add_probe(KIND_CM, PEER, 8'h00, cm_payload(CTL_RTS, 16'd10, 8'd2, 8'h00, 8'h30), 11'h000);
    add_probe(KIND_DT, PEER, 8'h00, 64'h55AA55AA55AA550A, 11'h000);
    add_probe(KIND_READ, 8'h00, 8'h00, 64'h0, 11'd1778);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) send_beat(probe_rows[i].beat, probe_rows[i].typed, probe_rows[i].want);

    // Random traffic under a series of register settings, extremes included.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: configure(8'h3A, 8'($urandom), 8'h00, 16'd5);
        1: configure(8'hFF, 8'hA5, 8'hFF, 16'd0);
        2: configure(8'h00, 8'h5A, 8'hF0, 16'd3);
        3: configure(8'($urandom), 8'($urandom), 8'($urandom), 16'hFFFF);
        4: configure(8'($urandom), 8'h00, 8'h0F, TIMEOUT_RESET);
        5: configure(8'($urandom), 8'($urandom), 8'h00, 16'd1);
        6: configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 12)));
        default: configure(8'h80, 8'($urandom), 8'h00, 16'd8);
      endcase
      run_phase(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== can_transport_reassembly_receiver.f =====
rtl/cantp_pkg.sv
rtl/cantp_ram.sv
rtl/cantp_bank.sv
rtl/can_transport_reassembly_receiver.sv
test/tb_can_transport_reassembly_receiver.sv
